// ===== hw/rtl/window_peak_to_peak_detector_assert.svh =====
// Assertion macros for the window peak-to-peak detector checker.
`ifndef WINDOW_PEAK_TO_PEAK_DETECTOR_ASSERT_SVH
`define WINDOW_PEAK_TO_PEAK_DETECTOR_ASSERT_SVH

// Checked at every edge outside of reset.
`define WPPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define WPPD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/wppd_pkg.sv =====
package wppd_pkg;

  localparam int DEF_CHANNELS    = 4;
  localparam int DEF_WINDOW      = 16;
  localparam int DEF_SAMPLE_BITS = 10;

  // Fixed field widths of the ports.
  localparam int NUM_FIELDS     = 4;
  localparam int FIELD_BITS     = 10;
  localparam int CFG_INDEX_BITS = 2;

  typedef struct packed {
    logic [FIELD_BITS-1:0] sample_ch3;
    logic [FIELD_BITS-1:0] sample_ch2;
    logic [FIELD_BITS-1:0] sample_ch1;
    logic [FIELD_BITS-1:0] sample_ch0;
  } sample_t;

  typedef struct packed {
    logic active_ch3;
    logic active_ch2;
    logic active_ch1;
    logic active_ch0;
  } result_t;

  // Sequencer to datapath.
  typedef struct packed {
    logic in_ready;
    logic scan;
    logic load;
  } ctrl_t;

  // Input side, datapath and output side to sequencer.
  typedef struct packed {
    logic in_valid;
    logic scan_last;
    logic out_free;
  } stat_t;

  // Jump conditions of a control word.
  typedef enum logic [1:0] {
    JC_GOTO     = 2'd0,
    JC_WAIT_IN  = 2'd1,
    JC_LOOP     = 2'd2,
    JC_WAIT_OUT = 2'd3
  } jc_t;

  localparam int STEP_BITS = 2;

  localparam logic [STEP_BITS-1:0] STEP_IDLE   = 2'd0;
  localparam logic [STEP_BITS-1:0] STEP_SCAN   = 2'd1;
  localparam logic [STEP_BITS-1:0] STEP_DRAIN  = 2'd2;
  localparam logic [STEP_BITS-1:0] STEP_RESULT = 2'd3;

  typedef struct packed {
    logic                 in_ready;
    logic                 scan;
    logic                 load;
    jc_t                  jump;
    logic [STEP_BITS-1:0] target;
  } uword_t;

  function automatic uword_t ucode_rom(input logic [STEP_BITS-1:0] step);
    uword_t w;
    w = '{in_ready: 1'b1, scan: 1'b0, load: 1'b0, jump: JC_WAIT_IN, target: STEP_SCAN};
    case (step)
      STEP_IDLE: begin
        w = '{in_ready: 1'b1, scan: 1'b0, load: 1'b0, jump: JC_WAIT_IN, target: STEP_SCAN};
      end
      STEP_SCAN: begin
        w = '{in_ready: 1'b0, scan: 1'b1, load: 1'b0, jump: JC_LOOP, target: STEP_DRAIN};
      end
      STEP_DRAIN: begin
        w = '{in_ready: 1'b0, scan: 1'b0, load: 1'b0, jump: JC_GOTO, target: STEP_RESULT};
      end
      STEP_RESULT: begin
        w = '{in_ready: 1'b0, scan: 1'b0, load: 1'b1, jump: JC_WAIT_OUT, target: STEP_IDLE};
      end
      default: begin
        w = '{in_ready: 1'b0, scan: 1'b0, load: 1'b0, jump: JC_GOTO, target: STEP_IDLE};
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/wppd_stream_if.sv =====
interface wppd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/wppd_sequencer.sv =====
module wppd_sequencer
  import wppd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctrl_t ctrl
);

  logic [STEP_BITS-1:0] step;
  logic [STEP_BITS-1:0] step_next;
  uword_t               word;

  assign word = ucode_rom(step);

  assign ctrl.in_ready = word.in_ready;
  assign ctrl.scan     = word.scan;
  assign ctrl.load     = word.load & stat.out_free;

  always_comb begin
    case (word.jump)
      JC_GOTO:     step_next = word.target;
      JC_WAIT_IN:  step_next = stat.in_valid  ? word.target : step;
      JC_LOOP:     step_next = stat.scan_last ? word.target : step;
      JC_WAIT_OUT: step_next = stat.out_free  ? word.target : step;
      default:     step_next = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== hw/rtl/wppd_datapath.sv =====
module wppd_datapath
  import wppd_pkg::*;
#(
  parameter int CHANNELS    = DEF_CHANNELS,
  parameter int WINDOW      = DEF_WINDOW,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ctrl_t                     ctrl,
  input  logic                      in_valid,
  input  sample_t                   sample,
  input  logic                      wr_en,
  input  logic [CFG_INDEX_BITS-1:0] wr_index,
  input  logic [FIELD_BITS-1:0]     wr_data,
  output logic                      scan_last,
  output logic [NUM_FIELDS-1:0]     active
);

  localparam int SLOT_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CH_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ROW_BITS  = CHANNELS * SAMPLE_BITS;
  localparam int CMP_BITS  = (SAMPLE_BITS > FIELD_BITS) ? SAMPLE_BITS : FIELD_BITS;
  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(WINDOW - 1);

  logic                              in_fire;
  logic [FIELD_BITS-1:0]             field [NUM_FIELDS];
  logic [FIELD_BITS+SAMPLE_BITS-1:0] wide;
  logic [ROW_BITS-1:0]               row_wr;

  logic [ROW_BITS-1:0] ring [WINDOW];
  logic [WINDOW-1:0]   row_valid;
  logic [SLOT_BITS-1:0] slot;
  logic [SLOT_BITS-1:0] scan_idx;
  logic [ROW_BITS-1:0] rd_row;
  logic                rd_ok;
  logic                rd_pend;

  logic [FIELD_BITS-1:0] threshold [CHANNELS];

  assign in_fire   = ctrl.in_ready & in_valid;
  assign scan_last = (scan_idx == LAST_SLOT);

  assign field[0] = sample.sample_ch0;
  assign field[1] = sample.sample_ch1;
  assign field[2] = sample.sample_ch2;
  assign field[3] = sample.sample_ch3;

  // Each sample is zero extended, then cut to the stored width.
  always_comb begin
    row_wr = '0;
    wide   = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      wide = {{SAMPLE_BITS{1'b0}}, field[ch]};
      row_wr[ch*SAMPLE_BITS +: SAMPLE_BITS] = wide[SAMPLE_BITS-1:0];
    end
  end

  // Ring memory: one row per round, all channels side by side.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ring[slot] <= row_wr;
    end
    rd_row <= ring[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      slot      <= '0;
      scan_idx  <= '0;
      rd_ok     <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      if (in_fire) begin
        row_valid[slot] <= 1'b1;
        slot            <= (slot == LAST_SLOT) ? '0 : slot + 1'b1;
        scan_idx        <= '0;
      end else if (ctrl.scan) begin
        scan_idx <= scan_idx + 1'b1;
      end
      rd_ok   <= row_valid[scan_idx];
      rd_pend <= ctrl.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        threshold[ch] <= '0;
      end
    end else if (wr_en && ({1'b0, wr_index} < (CFG_INDEX_BITS+1)'(CHANNELS))) begin
      threshold[wr_index[CH_BITS-1:0]] <= wr_data;
    end
  end

  for (genvar ch = 0; ch < NUM_FIELDS; ch++) begin : g_ch
    if (ch < CHANNELS) begin : g_used
      logic [SAMPLE_BITS-1:0] rd_val;
      logic [SAMPLE_BITS-1:0] hi;
      logic [SAMPLE_BITS-1:0] lo;
      logic [SAMPLE_BITS-1:0] span;

      // A row never written reads as zero.
      assign rd_val = rd_ok ? rd_row[ch*SAMPLE_BITS +: SAMPLE_BITS] : '0;

      always_ff @(posedge clk) begin
        if (in_fire) begin
          hi <= '0;
          lo <= '1;
        end else if (rd_pend) begin
          if (rd_val > hi) hi <= rd_val;
          if (rd_val < lo) lo <= rd_val;
        end
      end

      assign span       = hi - lo;
      assign active[ch] = CMP_BITS'(span) > CMP_BITS'(threshold[ch]);
    end else begin : g_unused
      assign active[ch] = 1'b0;
    end
  end

endmodule

// ===== hw/rtl/window_peak_to_peak_detector.sv =====
// A result becomes valid after its round is accepted, once the scan loop, the drain step
// and the result step (which waits for a free output register) have run. A new round is
// taken only back in idle, after the scan loop has read one ring row per cycle from the single read port of the ring.
// Reset (rst, synchronous): thresholds, write slot, row valid bits and sequencer
// clear at once; unwritten ring rows read as zero, so there is no clearing pass.
module window_peak_to_peak_detector
  import wppd_pkg::*;
#(
  parameter int CHANNELS    = DEF_CHANNELS,
  parameter int WINDOW      = DEF_WINDOW,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  wppd_stream_if.sink               samples,
  wppd_stream_if.source             results,
  input  logic                      wr_en,
  input  logic [CFG_INDEX_BITS-1:0] wr_index,
  input  logic [FIELD_BITS-1:0]     wr_data
);

  ctrl_t                 ctrl;
  stat_t                 stat;
  logic                  scan_last;
  logic [NUM_FIELDS-1:0] active;
  logic                  out_valid;
  result_t               out_data;

  assign stat.in_valid  = samples.valid;
  assign stat.scan_last = scan_last;
  assign stat.out_free  = ~out_valid | results.ready;

  wppd_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  wppd_datapath #(
    .CHANNELS    (CHANNELS),
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .in_valid  (samples.valid),
    .sample    (samples.data),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .scan_last (scan_last),
    .active    (active)
  );

  // Output register; frees the sequencer once the result is captured.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      out_data.active_ch0 <= active[0];
      out_data.active_ch1 <= active[1];
      out_data.active_ch2 <= active[2];
      out_data.active_ch3 <= active[3];
    end
  end

  assign samples.ready = ctrl.in_ready;
  assign results.valid = out_valid;
  assign results.data  = out_data;

endmodule

// ===== hw/rtl/wppd_checker.sv =====
`include "window_peak_to_peak_detector_assert.svh"

module wppd_checker
  import wppd_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_data
);

  `WPPD_ASSERT_ALWAYS(a_reset_clears_out, rst |=> !out_valid, "result valid after reset")
  `WPPD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")
  `WPPD_ASSERT(a_one_round, in_valid && in_ready |=> !in_ready, "second round taken during scan")
  `WPPD_ASSERT(a_result_after_scan, $rose(out_valid) |-> !$past(in_ready), "result without a scan")

endmodule

bind window_peak_to_peak_detector wppd_checker u_wppd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_data  (results.data)
);

// ===== sim/window_activity_check.sv =====
`timescale 1ns / 100ps

module window_activity_check
  import wppd_pkg::*;
#(
  parameter int CHANNELS    = DEF_CHANNELS,
  parameter int WINDOW      = DEF_WINDOW,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      samples_valid,
  input  logic                      samples_ready,
  input  sample_t                   samples_data,
  input  logic                      results_valid,
  input  logic                      results_ready,
  input  result_t                   results_data,
  input  logic                      wr_en,
  input  logic [CFG_INDEX_BITS-1:0] wr_index,
  input  logic [FIELD_BITS-1:0]     wr_data,
  output int                        pending,
  output int                        fail_count
);

  localparam logic [FIELD_BITS-1:0] SAMPLE_MASK = FIELD_BITS'((1 << SAMPLE_BITS) - 1);

  logic [FIELD_BITS-1:0] threshold [NUM_FIELDS];
  logic [FIELD_BITS-1:0] ring [NUM_FIELDS][WINDOW];
  int unsigned           slot;
  result_t               expected_activity [$];
  logic [NUM_FIELDS-1:0] want;
  logic [NUM_FIELDS-1:0] got;

  // Stores one round in the rings, then flags every channel whose window
  // range is strictly above its threshold.
  function automatic result_t record_round(input sample_t s);
    logic [NUM_FIELDS-1:0] act;
    logic [FIELD_BITS-1:0] hi;
    logic [FIELD_BITS-1:0] lo;
    act = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      ring[ch][slot] = s[ch*FIELD_BITS +: FIELD_BITS] & SAMPLE_MASK;
    end
    slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      hi = '0;
      lo = SAMPLE_MASK;
      for (int k = 0; k < WINDOW; k++) begin
        if (ring[ch][k] > hi) hi = ring[ch][k];
        if (ring[ch][k] < lo) lo = ring[ch][k];
      end
      act[ch] = (hi - lo) > threshold[ch];
    end
    return act;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int ch = 0; ch < NUM_FIELDS; ch++) begin
        threshold[ch] = '0;
        for (int k = 0; k < WINDOW; k++) ring[ch][k] = '0;
      end
      slot = 0;
      expected_activity.delete();
      fail_count = 0;
    end else begin
      if (wr_en) threshold[wr_index] = wr_data;
      if (results_valid && results_ready) begin
        if (expected_activity.size() == 0) begin
          $error("result transaction with no round outstanding: %b", results_data);
          fail_count++;
        end else begin
          want = expected_activity.pop_front();
          got  = results_data;
          for (int ch = 0; ch < NUM_FIELDS; ch++) begin
            if (got[ch] !== want[ch]) begin
              $error("active_ch%0d: expected %0b, actual %0b", ch, want[ch], got[ch]);
              fail_count++;
            end
          end
        end
      end
      if (samples_valid && samples_ready) begin
        expected_activity.push_back(record_round(samples_data));
      end
    end
    pending = expected_activity.size();
  end

endmodule

// ===== sim/tb_window_peak_to_peak_detector.sv =====
`timescale 1ns / 100ps

module tb_window_peak_to_peak_detector;
  import wppd_pkg::*;

  logic                      clk;
  logic                      rst;
  logic                      wr_en;
  logic [CFG_INDEX_BITS-1:0] wr_index;
  logic [FIELD_BITS-1:0]     wr_data;
  int                        pending;
  int                        fail_count;
  bit                        no_idle;

  wppd_stream_if #(.payload_t(sample_t)) samples_if ();
  wppd_stream_if #(.payload_t(result_t)) results_if ();

  window_peak_to_peak_detector uut (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples_if),
    .results  (results_if),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  window_activity_check u_check (
    .clk           (clk),
    .rst           (rst),
    .samples_valid (samples_if.valid),
    .samples_ready (samples_if.ready),
    .samples_data  (samples_if.data),
    .results_valid (results_if.valid),
    .results_ready (results_if.ready),
    .results_data  (results_if.data),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .pending       (pending),
    .fail_count    (fail_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Result side backpressure.
  always @(negedge clk) begin
    results_if.ready <= !rst && (no_idle || $urandom_range(99) >= 16);
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic sample_t round_of(input int c0, input int c1, input int c2, input int c3);
    sample_t s;
    s.sample_ch0 = FIELD_BITS'(c0);
    s.sample_ch1 = FIELD_BITS'(c1);
    s.sample_ch2 = FIELD_BITS'(c2);
    s.sample_ch3 = FIELD_BITS'(c3);
    return s;
  endfunction

  // Entered and left at a falling edge; valid stays high on exit.
  task automatic send_round(input sample_t s);
    while (!no_idle && $urandom_range(99) < 16) begin
      samples_if.valid <= 1'b0;
      @(negedge clk);
    end
    samples_if.valid <= 1'b1;
    samples_if.data  <= s;
    do @(posedge clk); while (!samples_if.ready);
    @(negedge clk);
  endtask

  task automatic drain_rounds();
    samples_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_thresholds(input int t0, input int t1, input int t2, input int t3);
    int t [NUM_FIELDS];
    t = '{t0, t1, t2, t3};
    for (int ch = 0; ch < NUM_FIELDS; ch++) begin
      wr_en    <= 1'b1;
      wr_index <= CFG_INDEX_BITS'(ch);
      wr_data  <= FIELD_BITS'(t[ch]);
      @(negedge clk);
    end
    wr_en <= 1'b0;
  endtask

  // Each channel gets a signal of random base and swing, with the threshold mostly
  // placed near the swing so both outcomes show up, and sometimes at 0 or 1023.
  task automatic random_phase(input int n);
    int      amp [NUM_FIELDS];
    int      base [NUM_FIELDS];
    int      thr [NUM_FIELDS];
    int      v;
    sample_t s;
    for (int ch = 0; ch < NUM_FIELDS; ch++) begin
      case ($urandom_range(3))
        0:       amp[ch] = $urandom_range(15);
        1:       amp[ch] = $urandom_range(255);
        2:       amp[ch] = 1023;
        default: amp[ch] = $urandom_range(1023);
      endcase
      base[ch] = $urandom_range(1023 - amp[ch]);
      case ($urandom_range(5))
        0:       thr[ch] = 0;
        1:       thr[ch] = 1023;
        default: begin
          thr[ch] = amp[ch] + int'($urandom_range(8)) - 4;
          if (thr[ch] < 0) thr[ch] = 0;
          if (thr[ch] > 1023) thr[ch] = 1023;
        end
      endcase
    end
    drain_rounds();
    write_thresholds(thr[0], thr[1], thr[2], thr[3]);
    repeat (n) begin
      for (int ch = 0; ch < NUM_FIELDS; ch++) begin
        if ($urandom_range(9) == 0) v = $urandom_range(1023);
        else v = base[ch] + int'($urandom_range(amp[ch]));
        s[ch*FIELD_BITS +: FIELD_BITS] = FIELD_BITS'(v);
      end
      send_round(s);
    end
  endtask

  initial begin
    rst              = 1'b1;
    wr_en            = 1'b0;
    wr_index         = '0;
    wr_data          = '0;
    no_idle          = 1'b0;
    samples_if.valid = 1'b0;
    samples_if.data  = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Thresholds at reset value: any nonzero range reports.
    send_round(round_of(0, 0, 0, 0));
    send_round(round_of(1, 1023, 0, 512));
    send_round(round_of(1023, 1023, 1023, 1023));
    send_round(round_of(10'h2AA, 10'h155, 10'h2AA, 10'h155));

    // Top threshold never reports; one below the full range does.
    drain_rounds();
    write_thresholds(1023, 1022, 0, 511);
    send_round(round_of(1023, 1023, 1023, 1023));
    send_round(round_of(0, 0, 0, 0));
    send_round(round_of(512, 1, 511, 1022));

    // Flush the window with a constant, then step one channel pair by one.
    drain_rounds();
    write_thresholds(0, 0, 0, 0);
    repeat (DEF_WINDOW) send_round(round_of(700, 700, 700, 700));
    send_round(round_of(701, 700, 699, 700));

    for (int p = 0; p < 5; p++) begin
      no_idle = (p == 2);
      random_phase(80);
    end
    no_idle = 1'b0;

    samples_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DEF_WINDOW + 4) @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/wppd_pkg.sv
hw/rtl/wppd_stream_if.sv
hw/rtl/wppd_sequencer.sv
hw/rtl/wppd_datapath.sv
hw/rtl/window_peak_to_peak_detector.sv
hw/rtl/wppd_checker.sv
sim/window_activity_check.sv
sim/tb_window_peak_to_peak_detector.sv
